// ----- rtl/ebp_pkg.sv -----
// types, constants and helpers for the extension block parser
package ebp_pkg;

	// position counter width and the compare width that holds position + 3
	localparam int POSITION_BITS = 16;
	localparam int POS_W = POSITION_BITS;
	localparam int CMP_W = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;

	// block constants
	localparam logic [31:0] BLOCK_SIGNATURE = 32'hbeef0004;
	localparam logic [15:0] MIN_BLOCK_LENGTH = 16'd20;
	localparam logic [15:0] VER_3 = 16'd3;
	localparam logic [15:0] VER_7 = 16'd7;
	localparam logic [15:0] VER_8 = 16'd8;
	localparam logic [15:0] VER_9 = 16'd9;
	localparam logic [5:0] HDR_END_3 = 6'd20;
	localparam logic [5:0] HDR_END_7 = 6'd38;
	localparam logic [5:0] HDR_END_8 = 6'd42;
	localparam logic [5:0] HDR_END_9 = 6'd46;
	localparam logic [5:0] HDR_NONE = 6'd0;
	localparam logic [5:0] SIZE_POS_OLD = 6'd18;
	localparam logic [5:0] SIZE_POS_NEW = 6'd36;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNSUP = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// byte role codes
	localparam logic [1:0] ROLE_HEADER = 2'd0;
	localparam logic [1:0] ROLE_LONG = 2'd1;
	localparam logic [1:0] ROLE_LOCAL = 2'd2;
	localparam logic [1:0] ROLE_TRAIL = 2'd3;

	// parse phase
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LONG,
		PH_LOCAL,
		PH_DONE
	} phase_t;

	// outcome of closing the long name
	typedef struct packed {
		phase_t ph;
		logic [POS_W-1:0] ns;
		logic [1:0] st;
	} al_t;

	// one result item
	typedef struct packed {
		logic [1:0] byte_role;
		logic [7:0] echo_byte;
		logic done_res;
		logic [1:0] status;
		logic [15:0] block_version;
		logic [31:0] creation_word;
		logic [31:0] access_word;
		logic [63:0] entry_reference;
		logic [15:0] long_name_length;
		logic [15:0] localized_name_length;
	} res_t;

	// position of the first byte after the header, zero for unknown versions
	function automatic logic [5:0] header_end(input logic [15:0] ver);
		logic [5:0] he;
		case (ver)
			VER_3: he = HDR_END_3;
			VER_7: he = HDR_END_7;
			VER_8: he = HDR_END_8;
			VER_9: he = HDR_END_9;
			default: he = HDR_NONE;
		endcase
		return he;
	endfunction

endpackage

// ----- rtl/extension_block_parser.sv -----
// extension block parser: byte-wise header capture, name scan and summary
//
// Input channel (in_valid/in_ready) takes one byte of a file-entry extension
// block per item, with the block length (sampled on the first byte) and a
// last flag on the final byte. Output channel (out_valid/out_ready) returns
// one result item per input item: the byte echoed with its role tag, and on
// the last byte the status and the captured summary fields.
// Each result is registered in the output or skid register. One item per
// cycle is sustained while the receiver takes results: each byte needs only
// position compares and small register updates before the output register.
// A two-entry output buffer (output register plus skid register) lets the
// block take one more item while a result waits; in_ready drops only when
// both entries are full, and rises again as soon as the receiver takes one.
// Reset clears all parse state and both buffer entries; the next byte is
// treated as byte 0 of a new block. After the last byte the parse state is
// cleared in the same way.
module extension_block_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic [15:0] block_length,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  byte_role,
	output logic [7:0]  echo_byte,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [15:0] block_version,
	output logic [31:0] creation_word,
	output logic [31:0] access_word,
	output logic [63:0] entry_reference,
	output logic [15:0] long_name_length,
	output logic [15:0] localized_name_length
);
	import ebp_pkg::*;

	// parse state
	logic [POS_W-1:0] pos_q;
	logic [15:0]      len_q;
	phase_t           phase_q;
	logic [31:0]      sig_q;
	logic [15:0]      ver_q;
	logic [31:0]      cre_q;
	logic [31:0]      acc_q;
	logic [63:0]      ref_q;
	logic [15:0]      ds_q;
	logic [POS_W-1:0] ns_q;
	logic [15:0]      lc_q;
	logic [15:0]      lcl_q;
	logic [7:0]       prev_q;
	logic [1:0]       sth_q;

	// next parse state and result
	logic [15:0]      len_c;
	phase_t           ph_c;
	logic [31:0]      sig_c;
	logic [15:0]      ver_c;
	logic [31:0]      cre_c;
	logic [31:0]      acc_c;
	logic [63:0]      ref_c;
	logic [15:0]      ds_c;
	logic [POS_W-1:0] ns_c;
	logic [15:0]      lc_c;
	logic [15:0]      lcl_c;
	logic [1:0]       sth_c;
	res_t             res_c;

	// output buffer
	res_t out_q;
	res_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic in_fire;
	logic out_fire;

	// close the long name: start the localized name or finish
	function automatic al_t after_long(input logic [CMP_W-1:0] q,
			input logic [POS_W-1:0] ns_in, input logic [1:0] st_in,
			input logic [15:0] ds, input logic [15:0] ver,
			input logic [CMP_W-1:0] lw);
		al_t res;
		res.ph = PH_LOCAL;
		res.ns = ns_in;
		res.st = st_in;
		if (ds == '0) begin
			res.ph = PH_DONE;
			res.st = ST_OK;
		end else begin
			res.ns = POS_W'(q);
			if (q >= lw) begin
				res.ph = PH_DONE;
				res.st = ST_UNSUP;
			end else if ((ver >= VER_7) ? (q + CMP_W'(3) >= lw) : (q + CMP_W'(2) >= lw)) begin
				res.ph = PH_DONE;
				res.st = ST_EMPTY;
			end
		end
		return res;
	endfunction

	// per-byte parse step
	always_comb begin
		logic [CMP_W-1:0] pw;
		logic [CMP_W-1:0] lw;
		logic [CMP_W-1:0] he;
		logic [CMP_W-1:0] dsp;
		logic [POS_W-1:0] r;
		logic [POS_W:0]   cnt1;
		logic [2:0]       ref_idx;
		logic [1:0]       role;
		logic [1:0]       st;
		al_t              al;

		len_c = (pos_q == '0) ? block_length : len_q;
		ph_c  = phase_q;
		sig_c = sig_q;
		ver_c = ver_q;
		cre_c = cre_q;
		acc_c = acc_q;
		ref_c = ref_q;
		ds_c  = ds_q;
		ns_c  = ns_q;
		lc_c  = lc_q;
		lcl_c = lcl_q;
		sth_c = sth_q;
		role  = ROLE_HEADER;
		dsp   = '0;
		al    = '0;
		pw    = CMP_W'(pos_q);
		lw    = CMP_W'(len_c);
		he    = CMP_W'(header_end(ver_q));
		ref_idx = 3'(pos_q - POS_W'(20));

		// header end reached: long name starts here
		if (ph_c == PH_HEADER && pw >= CMP_W'(8) && pw == he) begin
			ph_c = PH_LONG;
			ns_c = pos_q;
			if (pw + CMP_W'(3) >= lw) begin
				ph_c  = PH_DONE;
				sth_c = ST_EMPTY;
			end
		end

		// long name hits the scan limit
		r = pos_q - ns_c;
		if (ph_c == PH_LONG && !r[0] && pw + CMP_W'(3) >= lw) begin
			lc_c = 16'(r);
			al = after_long(pw, ns_c, sth_c, ds_c, ver_c, lw);
			ph_c  = al.ph;
			ns_c  = al.ns;
			sth_c = al.st;
		end

		// localized name hits the scan limit
		r = pos_q - ns_c;
		if (ph_c == PH_LOCAL) begin
			if ((ver_c >= VER_7) ? (!r[0] && pw + CMP_W'(3) >= lw) : (pw + CMP_W'(2) >= lw)) begin
				lcl_c = 16'(r);
				ph_c  = PH_DONE;
				sth_c = ST_OK;
			end
		end

		// work on this byte
		r = pos_q - ns_c;
		cnt1 = {1'b0, r} + (POS_W + 1)'(1);
		case (ph_c)
			PH_HEADER: begin
				role = ROLE_HEADER;
				if (pw == CMP_W'(2)) ver_c[7:0] = byte_value;
				else if (pw == CMP_W'(3)) ver_c[15:8] = byte_value;
				else if (pw inside {[4:7]}) sig_c = {byte_value, sig_c[31:8]};
				else if (pw inside {[8:11]}) cre_c[8*pos_q[1:0] +: 8] = byte_value;
				else if (pw inside {[12:15]}) acc_c[8*pos_q[1:0] +: 8] = byte_value;
				if (ver_c >= VER_7 && (pw inside {[20:27]}))
					ref_c[8*ref_idx +: 8] = byte_value;
				dsp = (ver_c >= VER_7) ? CMP_W'(SIZE_POS_NEW) : CMP_W'(SIZE_POS_OLD);
				if (pw == dsp) ds_c[7:0] = byte_value;
				else if (pw == dsp + CMP_W'(1)) ds_c[15:8] = byte_value;
				if (pw == CMP_W'(7)) begin
					he = CMP_W'(header_end(ver_c));
					if (len_c < MIN_BLOCK_LENGTH || sig_c != BLOCK_SIGNATURE ||
							he == '0 || lw <= he) begin
						ph_c  = PH_DONE;
						sth_c = ST_UNSUP;
					end
				end
			end
			PH_LONG: begin
				role = ROLE_LONG;
				if (r[0] && prev_q == 8'd0 && byte_value == 8'd0) begin
					lc_c = 16'(cnt1);
					al = after_long(pw + CMP_W'(1), ns_c, sth_c, ds_c, ver_c, lw);
					ph_c  = al.ph;
					ns_c  = al.ns;
					sth_c = al.st;
				end
			end
			PH_LOCAL: begin
				role = ROLE_LOCAL;
				if ((ver_c >= VER_7) ? (r[0] && prev_q == 8'd0 && byte_value == 8'd0)
						: (byte_value == 8'd0)) begin
					lcl_c = 16'(cnt1);
					ph_c  = PH_DONE;
					sth_c = ST_OK;
				end
			end
			default: begin
				role = ROLE_TRAIL;
			end
		endcase

		// result item
		st = (ph_c == PH_DONE) ? sth_c : ST_UNSUP;
		res_c = '0;
		res_c.byte_role = role;
		res_c.echo_byte = byte_value;
		res_c.done_res  = last;
		if (last) begin
			res_c.status = st;
			if (st != ST_UNSUP) begin
				res_c.block_version   = ver_c;
				res_c.creation_word   = cre_c;
				res_c.access_word     = acc_c;
				res_c.entry_reference = ref_c;
				if (st == ST_OK) begin
					res_c.long_name_length      = lc_c;
					res_c.localized_name_length = lcl_c;
				end
			end
		end
	end

	// handshakes
	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	// parse state registers, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			phase_q <= PH_HEADER;
			sig_q   <= '0;
			ver_q   <= '0;
			cre_q   <= '0;
			acc_q   <= '0;
			ref_q   <= '0;
			ds_q    <= '0;
			ns_q    <= '0;
			lc_q    <= '0;
			lcl_q   <= '0;
			prev_q  <= '0;
			sth_q   <= ST_OK;
		end else if (in_fire) begin
			if (last) begin
				pos_q   <= '0;
				len_q   <= '0;
				phase_q <= PH_HEADER;
				sig_q   <= '0;
				ver_q   <= '0;
				cre_q   <= '0;
				acc_q   <= '0;
				ref_q   <= '0;
				ds_q    <= '0;
				ns_q    <= '0;
				lc_q    <= '0;
				lcl_q   <= '0;
				prev_q  <= '0;
				sth_q   <= ST_OK;
			end else begin
				pos_q   <= (pos_q == '1) ? pos_q : pos_q + POS_W'(1);
				len_q   <= len_c;
				phase_q <= ph_c;
				sig_q   <= sig_c;
				ver_q   <= ver_c;
				cre_q   <= cre_c;
				acc_q   <= acc_c;
				ref_q   <= ref_c;
				ds_q    <= ds_c;
				ns_q    <= ns_c;
				lc_q    <= lc_c;
				lcl_q   <= lcl_c;
				prev_q  <= byte_value;
				sth_q   <= sth_c;
			end
		end
	end

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_fire) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// buffer payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_fire) begin
			out_q <= skid_valid_q ? skid_q : res_c;
		end else if (in_fire) begin
			skid_q <= res_c;
		end
	end

	// output ports
	assign out_valid             = out_valid_q;
	assign byte_role             = out_q.byte_role;
	assign echo_byte             = out_q.echo_byte;
	assign done_res              = out_q.done_res;
	assign status                = out_q.status;
	assign block_version         = out_q.block_version;
	assign creation_word         = out_q.creation_word;
	assign access_word           = out_q.access_word;
	assign entry_reference       = out_q.entry_reference;
	assign long_name_length      = out_q.long_name_length;
	assign localized_name_length = out_q.localized_name_length;

	// checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds an item while the output register is empty");

	a_last_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last |=> pos_q == '0 && phase_q == PH_HEADER)
		else $error("parse state not cleared after the last byte");

	a_mid_block_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.done_res |-> out_q.status == ST_OK &&
			out_q.block_version == '0 && out_q.long_name_length == '0)
		else $error("summary fields set on a result that is not the last byte");

	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_UNSUP |-> out_q.block_version == '0 &&
			out_q.entry_reference == '0 && out_q.localized_name_length == '0)
		else $error("summary fields set on an unsupported block");

endmodule
